FILE: design/pingpong_frame_sequencer_top_macros.svh
// Assertion macros shared by the frame sequencer modules.
// Included by pfs_div and pfs_seq; no other dependencies.
`ifndef PINGPONG_FRAME_SEQUENCER_TOP_MACROS_SVH
`define PINGPONG_FRAME_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: ante |-> cons
`define PFS_ASSERT_IMPL(name, c, r, ante, cons, msg) \
    name: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: ante |=> cons
`define PFS_ASSERT_NEXT(name, c, r, ante, cons, msg) \
    name: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFS_ASSERT_IMPL(name, c, r, ante, cons, msg)
`define PFS_ASSERT_NEXT(name, c, r, ante, cons, msg)
`endif
`endif

FILE: design/pfs_pkg.sv
// Shared types, register codes and constants for the frame sequencer.
// No dependencies; used by every module of the block.
package pfs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int FRAME_CAP  = (MAX_FRAMES > 256) ? 256 : MAX_FRAMES;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 36;
    localparam int DIV_W      = 32;
    localparam int DSR_W      = 12;
    localparam int CNT_W      = 6;

    localparam logic [14:0] PERCENT_SCALE = 15'd100;
    localparam logic [CNT_W-1:0] PCT_ITERS  = 6'd15;
    localparam logic [CNT_W-1:0] WORD_ITERS = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT      = 4'd0,
        CFG_PHASE_DELAYS     = 4'd1,
        CFG_PHASE_THRESHOLDS = 4'd2,
        CFG_PEAK_PAUSE_MIN   = 4'd3,
        CFG_PEAK_PAUSE_MAX   = 4'd4,
        CFG_REST_PAUSE_MIN   = 4'd5,
        CFG_REST_PAUSE_MAX   = 4'd6,
        CFG_JITTER_SPAN      = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  last_frame;
        logic [11:0] d_start;
        logic [11:0] d_mid;
        logic [11:0] d_end;
        logic [6:0]  t_start;
        logic [6:0]  t_end;
        logic [11:0] peak_min;
        logic [11:0] peak_max;
        logic [11:0] rest_min;
        logic [11:0] rest_max;
        logic [7:0]  jitter_span;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PCT,
        ST_JIT,
        ST_PAUSE,
        ST_FIN
    } pfs_state_t;

endpackage

FILE: design/pfs_cfg.sv
// Configuration register file and effective last-frame computation.
// Depends on pfs_pkg.
module pfs_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pfs_pkg::cfg_t                    cfg
);

    localparam logic [8:0] CAP = 9'(pfs_pkg::FRAME_CAP);

    logic [8:0]  frame_count_reg, frame_count_next;
    logic [35:0] delays_reg, delays_next;
    logic [13:0] thresholds_reg, thresholds_next;
    logic [11:0] peak_min_reg, peak_min_next;
    logic [11:0] peak_max_reg, peak_max_next;
    logic [11:0] rest_min_reg, rest_min_next;
    logic [11:0] rest_max_reg, rest_max_next;
    logic [7:0]  jitter_span_reg, jitter_span_next;
    logic [8:0]  eff_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        delays_next      = delays_reg;
        thresholds_next  = thresholds_reg;
        peak_min_next    = peak_min_reg;
        peak_max_next    = peak_max_reg;
        rest_min_next    = rest_min_reg;
        rest_max_next    = rest_max_reg;
        jitter_span_next = jitter_span_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pfs_pkg::CFG_FRAME_COUNT:      frame_count_next = cfg_data[8:0];
                pfs_pkg::CFG_PHASE_DELAYS:     delays_next      = cfg_data[35:0];
                pfs_pkg::CFG_PHASE_THRESHOLDS: thresholds_next  = cfg_data[13:0];
                pfs_pkg::CFG_PEAK_PAUSE_MIN:   peak_min_next    = cfg_data[11:0];
                pfs_pkg::CFG_PEAK_PAUSE_MAX:   peak_max_next    = cfg_data[11:0];
                pfs_pkg::CFG_REST_PAUSE_MIN:   rest_min_next    = cfg_data[11:0];
                pfs_pkg::CFG_REST_PAUSE_MAX:   rest_max_next    = cfg_data[11:0];
                pfs_pkg::CFG_JITTER_SPAN:      jitter_span_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 9'd2;
            delays_reg      <= '0;
            thresholds_reg  <= '0;
            peak_min_reg    <= '0;
            peak_max_reg    <= '0;
            rest_min_reg    <= '0;
            rest_max_reg    <= '0;
            jitter_span_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            delays_reg      <= delays_next;
            thresholds_reg  <= thresholds_next;
            peak_min_reg    <= peak_min_next;
            peak_max_reg    <= peak_max_next;
            rest_min_reg    <= rest_min_next;
            rest_max_reg    <= rest_max_next;
            jitter_span_reg <= jitter_span_next;
        end
    end

    // Clamp the frame count into 2..cap
    always_comb
    begin
        priority if (frame_count_reg < 9'd2)
            eff_count = 9'd2;
        else if (frame_count_reg > CAP)
            eff_count = CAP;
        else
            eff_count = frame_count_reg;
    end

    always_comb
    begin
        cfg.last_frame  = 8'(eff_count - 9'd1);
        cfg.d_start     = delays_reg[11:0];
        cfg.d_mid       = delays_reg[23:12];
        cfg.d_end       = delays_reg[35:24];
        cfg.t_start     = thresholds_reg[6:0];
        cfg.t_end       = thresholds_reg[13:7];
        cfg.peak_min    = peak_min_reg;
        cfg.peak_max    = peak_max_reg;
        cfg.rest_min    = rest_min_reg;
        cfg.rest_max    = rest_max_reg;
        cfg.jitter_span = jitter_span_reg;
    end

endmodule

FILE: design/pfs_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pfs_pkg and the assertion macro header.
`include "pingpong_frame_sequencer_top_macros.svh"
module pfs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pfs_pkg::div_req_t   div_req,
    output pfs_pkg::div_rsp_t   div_rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pfs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [pfs_pkg::DIV_W-1:0]  dvd_reg, dvd_next;
    logic [pfs_pkg::DSR_W-1:0]  rem_reg, rem_next;
    logic [pfs_pkg::DSR_W-1:0]  dsr_reg, dsr_next;
    logic [12:0]                trial;
    logic [13:0]                diff;
    logic                       ge;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, dvd_reg[pfs_pkg::DIV_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge    = !diff[13];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[pfs_pkg::DIV_W-2:0], ge};
            rem_next = ge ? diff[11:0] : trial[11:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = div_req.iters;
            dvd_next  = div_req.dividend;
            dsr_next  = div_req.divisor;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign div_rsp.busy = busy_reg;
    assign div_rsp.done = done_reg;
    assign div_rsp.quot = dvd_reg;
    assign div_rsp.rem  = rem_reg;

    `PFS_ASSERT_IMPL(a_no_start_busy, clk, rst_n, div_req.start, !busy_reg, "divider restarted while busy")
    `PFS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "divider done held two cycles")
    `PFS_ASSERT_NEXT(a_done_follows, clk, rst_n, busy_reg && cnt_reg == 6'd1, done_reg, "divider finished without done")

endmodule

FILE: design/pfs_seq.sv
// Step sequencer: holds frame state and deadline, drives the shared divider.
// Depends on pfs_pkg and the assertion macro header.
`include "pingpong_frame_sequencer_top_macros.svh"
module pfs_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          now_ms,
    input  logic [31:0]          jitter_random,
    input  logic [31:0]          pause_random,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           frame_index,
    output logic                 rising,
    output logic                 stepped,
    input  pfs_pkg::cfg_t        cfg,
    output pfs_pkg::div_req_t    div_req,
    input  pfs_pkg::div_rsp_t    div_rsp
);

    pfs_pkg::pfs_state_t state_reg, state_next;

    logic [31:0] now_reg, now_next;
    logic [31:0] jrnd_reg, jrnd_next;
    logic [31:0] prnd_reg, prnd_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [7:0]  frame_reg, frame_next;
    logic        going_up_reg, going_up_next;
    logic        hit_reg, hit_next;
    logic        at_end_reg, at_end_next;
    logic [11:0] base_reg, base_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_frame_reg, out_frame_next;
    logic        out_rising_reg, out_rising_next;
    logic        out_stepped_reg, out_stepped_next;

    logic [8:0]  frame_inc;
    logic        hit;
    logic        at_end;
    logic [11:0] pause_lo;
    logic [11:0] pause_hi;
    logic [11:0] pause_range;
    logic        pause_open;
    logic [14:0] pct_prod;
    logic [14:0] pct;
    logic [11:0] base_sel;
    logic [13:0] delay_sum;
    logic [12:0] delay;
    logic [7:0]  frame_new;
    logic        going_up_new;
    logic        fin_take;

    assign frame_inc = {1'b0, frame_reg} + 9'd1;
    assign hit       = now_reg >= deadline_reg;
    assign at_end    = going_up_reg ? (frame_inc >= {1'b0, cfg.last_frame})
                                    : (frame_reg <= 8'd1);

    // Peak pause on the way up, rest pause on the way down
    assign pause_lo    = going_up_reg ? cfg.peak_min : cfg.rest_min;
    assign pause_hi    = going_up_reg ? cfg.peak_max : cfg.rest_max;
    assign pause_open  = pause_hi > pause_lo;
    assign pause_range = pause_hi - pause_lo;

    assign pct_prod = {7'b0, frame_reg} * pfs_pkg::PERCENT_SCALE;
    assign pct      = div_rsp.quot[14:0];

    always_comb
    begin
        if (going_up_reg)
        begin
            priority if (pct < {8'b0, cfg.t_start})
                base_sel = cfg.d_start;
            else if (pct < {8'b0, cfg.t_end})
                base_sel = cfg.d_mid;
            else
                base_sel = cfg.d_end;
        end
        else
        begin
            priority if (pct > {8'b0, cfg.t_end})
                base_sel = cfg.d_end;
            else if (pct > {8'b0, cfg.t_start})
                base_sel = cfg.d_mid;
            else
                base_sel = cfg.d_start;
        end
    end

    // base + (rnd mod 2v+1) - v, clamped at zero
    assign delay_sum = {2'b00, base_reg} + {5'b0, div_rsp.rem[8:0]}
                     - {6'b0, cfg.jitter_span};
    assign delay     = delay_sum[13] ? 13'd0 : delay_sum[12:0];

    always_comb
    begin
        if (going_up_reg)
        begin
            frame_new    = at_end_reg ? cfg.last_frame : frame_inc[7:0];
            going_up_new = !at_end_reg;
        end
        else
        begin
            frame_new    = (frame_reg == 8'd0) ? 8'd0 : frame_reg - 8'd1;
            going_up_new = at_end_reg;
        end
    end

    assign fin_take = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == pfs_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfs_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pfs_pkg::ST_EVAL;
            pfs_pkg::ST_EVAL:
                priority if (!hit)
                    state_next = pfs_pkg::ST_FIN;
                else if (at_end)
                    state_next = pause_open ? pfs_pkg::ST_PAUSE : pfs_pkg::ST_FIN;
                else
                    state_next = pfs_pkg::ST_PCT;
            pfs_pkg::ST_PCT:
                if (div_rsp.done)
                    state_next = pfs_pkg::ST_JIT;
            pfs_pkg::ST_JIT:
                if (div_rsp.done)
                    state_next = pfs_pkg::ST_FIN;
            pfs_pkg::ST_PAUSE:
                if (div_rsp.done)
                    state_next = pfs_pkg::ST_FIN;
            pfs_pkg::ST_FIN:
                if (fin_take)
                    state_next = pfs_pkg::ST_IDLE;
            default:
                state_next = pfs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and divider requests
    always_comb
    begin
        now_next         = now_reg;
        jrnd_next        = jrnd_reg;
        prnd_next        = prnd_reg;
        deadline_next    = deadline_reg;
        frame_next       = frame_reg;
        going_up_next    = going_up_reg;
        hit_next         = hit_reg;
        at_end_next      = at_end_reg;
        base_next        = base_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_frame_next   = out_frame_reg;
        out_rising_next  = out_rising_reg;
        out_stepped_next = out_stepped_reg;
        div_req          = '0;
        unique case (state_reg)
            pfs_pkg::ST_IDLE:
                if (in_valid)
                begin
                    now_next  = now_ms;
                    jrnd_next = jitter_random;
                    prnd_next = pause_random;
                end
            pfs_pkg::ST_EVAL:
            begin
                hit_next    = hit;
                at_end_next = at_end;
                if (hit)
                begin
                    if (at_end)
                    begin
                        if (pause_open)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = prnd_reg;
                            div_req.divisor  = pause_range;
                            div_req.iters    = pfs_pkg::WORD_ITERS;
                        end
                        else
                        begin
                            deadline_next = now_reg + {20'b0, pause_lo};
                        end
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {pct_prod, 17'b0};
                        div_req.divisor  = {4'b0, cfg.last_frame};
                        div_req.iters    = pfs_pkg::PCT_ITERS;
                    end
                end
            end
            pfs_pkg::ST_PCT:
                if (div_rsp.done)
                begin
                    base_next        = base_sel;
                    div_req.start    = 1'b1;
                    div_req.dividend = jrnd_reg;
                    div_req.divisor  = {3'b0, cfg.jitter_span, 1'b1};
                    div_req.iters    = pfs_pkg::WORD_ITERS;
                end
            pfs_pkg::ST_JIT:
                if (div_rsp.done)
                    deadline_next = now_reg + {19'b0, delay};
            pfs_pkg::ST_PAUSE:
                if (div_rsp.done)
                    deadline_next = now_reg + {20'b0, pause_lo} + {20'b0, div_rsp.rem};
            pfs_pkg::ST_FIN:
                if (fin_take)
                begin
                    out_valid_next   = 1'b1;
                    out_stepped_next = hit_reg;
                    if (hit_reg)
                    begin
                        frame_next      = frame_new;
                        going_up_next   = going_up_new;
                        out_frame_next  = frame_new;
                        out_rising_next = going_up_new;
                    end
                    else
                    begin
                        out_frame_next  = frame_reg;
                        out_rising_next = going_up_reg;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfs_pkg::ST_IDLE;
            deadline_reg  <= '0;
            frame_reg     <= '0;
            going_up_reg  <= 1'b1;
            hit_reg       <= 1'b0;
            at_end_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deadline_reg  <= deadline_next;
            frame_reg     <= frame_next;
            going_up_reg  <= going_up_next;
            hit_reg       <= hit_next;
            at_end_reg    <= at_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        jrnd_reg        <= jrnd_next;
        prnd_reg        <= prnd_next;
        base_reg        <= base_next;
        out_frame_reg   <= out_frame_next;
        out_rising_reg  <= out_rising_next;
        out_stepped_reg <= out_stepped_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = out_frame_reg;
    assign rising      = out_rising_reg;
    assign stepped     = out_stepped_reg;

    `PFS_ASSERT_IMPL(a_div_owner, clk, rst_n, div_rsp.busy, state_reg == pfs_pkg::ST_PCT || state_reg == pfs_pkg::ST_JIT || state_reg == pfs_pkg::ST_PAUSE, "divider busy outside a divide state")
    `PFS_ASSERT_NEXT(a_reverse, clk, rst_n, state_reg == pfs_pkg::ST_FIN && fin_take && hit_reg && at_end_reg, going_up_reg == !$past(going_up_reg), "no reversal at sequence end")
    `PFS_ASSERT_NEXT(a_step_up, clk, rst_n, state_reg == pfs_pkg::ST_FIN && fin_take && hit_reg && !at_end_reg && going_up_reg, frame_reg == $past(frame_reg) + 8'd1, "rising step did not advance by one")

endmodule

FILE: design/pingpong_frame_sequencer_top.sv
// Top level of the ping-pong frame sequencer.
// Depends on pfs_pkg, pfs_cfg, pfs_div and pfs_seq.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   now_ms, jitter_random, pause_random
//   out      source     out_valid / out_ready frame_index, rising, stepped
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is handled at a time; in_ready is high only while the sequencer idles.
// A sample that misses the deadline needs no divide. A step inside the sequence runs
// a 15-bit progress divide, then a 32-bit jitter modulo, both on the
// one shared bit-serial divider. A step that reaches either end skips the progress
// divide and runs one 32-bit pause modulo, or none if the range is empty.
// The result sits in an output register, so a stalled out channel only holds the
// sequencer in its final state; reset clears frame 0, rising, deadline 0.
module pingpong_frame_sequencer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [31:0]                      now_ms,
    input  logic [31:0]                      jitter_random,
    input  logic [31:0]                      pause_random,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       frame_index,
    output logic                             rising,
    output logic                             stepped,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Decoded configuration; the user must hold it stable while requests are in flight, the block does not enforce it
    pfs_pkg::cfg_t     cfg;
    // Shared divider request and response
    pfs_pkg::div_req_t div_req;
    pfs_pkg::div_rsp_t div_rsp;

    // Register file; also clamps the frame count into its legal range
    pfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // One quotient bit per cycle; serves the progress percent, jitter and pause
    pfs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Sequencer: compares against the deadline, orders the divides,
    // advance or reverse the frame, and load the output register
    pfs_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .jitter_random (jitter_random),
        .pause_random  (pause_random),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_index   (frame_index),
        .rising        (rising),
        .stepped       (stepped),
        .cfg           (cfg),
        .div_req       (div_req),
        .div_rsp       (div_rsp)
    );

endmodule

FILE: sim/tb_pingpong_frame_sequencer_top.sv
// Self-checking testbench for pingpong_frame_sequencer_top: a scoreboard class predicts
// every frame step, plain tasks drive the sample and register channels, and a process the result side.
// Depends on pfs_pkg and the design files of the frame sequencer.
module tb_pingpong_frame_sequencer_top;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int LONG_HOLD       = 400;
    localparam int TAIL_CYCLES     = 80;
    localparam int unsigned PCT_FULL = 100;

    typedef struct packed {
        logic [7:0] frame;
        logic       rising;
        logic       stepped;
    } frame_result_t;

    typedef struct packed {
        logic [8:0]  frames;
        logic [35:0] delays;
        logic [13:0] thresholds;
        logic [11:0] peak_min;
        logic [11:0] peak_max;
        logic [11:0] rest_min;
        logic [11:0] rest_max;
        logic [7:0]  span;
    } settings_t;

    // Own copy of the sequencer: registers, frame state, and the queue of frames
    // that the block still owes.
    class frame_seq_scoreboard;
        logic [8:0]  frame_count;
        logic [35:0] phase_delays;
        logic [13:0] phase_thresholds;
        logic [11:0] peak_min;
        logic [11:0] peak_max;
        logic [11:0] rest_min;
        logic [11:0] rest_max;
        logic [7:0]  jitter_span;
        logic [7:0]  frame;
        logic        going_up;
        logic [31:0] deadline;
        frame_result_t pending_frames[$];
        int errors;
        int samples;
        int steps;
        int reversals;
        int clamped;
        int beyond_last;

        function new();
            frame_count      = 9'd2;
            phase_delays     = '0;
            phase_thresholds = '0;
            peak_min         = '0;
            peak_max         = '0;
            rest_min         = '0;
            rest_max         = '0;
            jitter_span      = '0;
            frame            = '0;
            going_up         = 1'b1;
            deadline         = '0;
            errors           = 0;
            samples          = 0;
            steps            = 0;
            reversals        = 0;
            clamped          = 0;
            beyond_last      = 0;
        endfunction

        function void load_reg(pfs_pkg::cfg_reg_t idx, logic [35:0] data);
            case (idx)
                pfs_pkg::CFG_FRAME_COUNT:      frame_count = data[8:0];
                pfs_pkg::CFG_PHASE_DELAYS:     phase_delays = data;
                pfs_pkg::CFG_PHASE_THRESHOLDS: phase_thresholds = data[13:0];
                pfs_pkg::CFG_PEAK_PAUSE_MIN:   peak_min = data[11:0];
                pfs_pkg::CFG_PEAK_PAUSE_MAX:   peak_max = data[11:0];
                pfs_pkg::CFG_REST_PAUSE_MIN:   rest_min = data[11:0];
                pfs_pkg::CFG_REST_PAUSE_MAX:   rest_max = data[11:0];
                pfs_pkg::CFG_JITTER_SPAN:      jitter_span = data[7:0];
                default: ;
            endcase
        endfunction

        // Empty or inverted range: the minimum alone.
        function logic [31:0] pause_len(logic [11:0] lo, logic [11:0] hi, logic [31:0] rnd);
            logic [31:0] range_w;
            range_w = '0;
            if (hi > lo)
            begin
                range_w = {20'b0, hi - lo};
                return {20'b0, lo} + rnd % range_w;
            end
            return {20'b0, lo};
        endfunction

        function void note_sample(logic [31:0] now, logic [31:0] jrnd, logic [31:0] prnd);
            int unsigned last;
            int unsigned pct;
            int unsigned base;
            int unsigned t_start;
            int unsigned t_end;
            int unsigned span_w;
            int unsigned jmod;
            int unsigned nxt;
            int delay;
            frame_result_t r;
            samples++;
            r.stepped = 1'b0;
            if (now >= deadline)
            begin
                // Clamp the frame count into 2..cap before taking the last index.
                if (frame_count < 9'd2)
                    last = 1;
                else if (32'(frame_count) > unsigned'(pfs_pkg::FRAME_CAP))
                    last = unsigned'(pfs_pkg::FRAME_CAP - 1);
                else
                    last = 32'(frame_count) - 1;
                pct = 32'(frame) * PCT_FULL / last;
                if (32'(frame) > last)
                    beyond_last++;
                t_start = 32'(phase_thresholds[6:0]);
                t_end   = 32'(phase_thresholds[13:7]);
                if (going_up)
                begin
                    if (pct < t_start)
                        base = 32'(phase_delays[11:0]);
                    else if (pct < t_end)
                        base = 32'(phase_delays[23:12]);
                    else
                        base = 32'(phase_delays[35:24]);
                end
                else
                begin
                    if (pct > t_end)
                        base = 32'(phase_delays[35:24]);
                    else if (pct > t_start)
                        base = 32'(phase_delays[23:12]);
                    else
                        base = 32'(phase_delays[11:0]);
                end
                span_w = 2 * 32'(jitter_span) + 1;
                jmod = jrnd % span_w;
                delay = int'(base) + int'(jmod) - int'(jitter_span);
                if (delay < 0)
                begin
                    delay = 0;
                    clamped++;
                end
                deadline = now + unsigned'(delay);
                if (going_up)
                begin
                    nxt = 32'(frame) + 1;
                    if (nxt >= last)
                    begin
                        frame = last[7:0];
                        going_up = 1'b0;
                        deadline = now + pause_len(peak_min, peak_max, prnd);
                        reversals++;
                    end
                    else
                        frame = nxt[7:0];
                end
                else
                begin
                    if (frame != 8'd0)
                        frame = frame - 8'd1;
                    if (frame == 8'd0)
                    begin
                        going_up = 1'b1;
                        deadline = now + pause_len(rest_min, rest_max, prnd);
                        reversals++;
                    end
                end
                steps++;
                r.stepped = 1'b1;
            end
            r.frame = frame;
            r.rising = going_up;
            pending_frames.push_back(r);
        endfunction

        function void check_result(logic [7:0] fi, logic ri, logic st);
            frame_result_t exp_r;
            if (pending_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: frame %0d rising %0d stepped %0d",
                             fi, ri, st);
                return;
            end
            exp_r = pending_frames.pop_front();
            if (fi !== exp_r.frame || ri !== exp_r.rising || st !== exp_r.stepped)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch (exp/got): frame %0d/%0d rising %0d/%0d stepped %0d/%0d",
                             exp_r.frame, fi, exp_r.rising, ri, exp_r.stepped, st);
            end
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] now_ms;
    logic [31:0] jitter_random;
    logic [31:0] pause_random;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_index;
    logic        rising;
    logic        stepped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data;

    frame_seq_scoreboard board;
    settings_t cfg_now;
    bit calm;            // no gaps on either side while set
    int hold_requests;   // bumped by the sender to ask for one long receiver hold-off

    pingpong_frame_sequencer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .jitter_random (jitter_random),
        .pause_random  (pause_random),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_index   (frame_index),
        .rising        (rising),
        .stepped       (stepped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 50)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Mostly small delays so that several phases fit in few samples.
    function automatic logic [11:0] rand_delay();
        if ($urandom_range(0, 9) < 7)
            return 12'($urandom_range(0, 60));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] rand_pause();
        if ($urandom_range(0, 9) < 7)
            return 12'($urandom_range(0, 40));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        int r;
        r = int'($urandom_range(0, 99));
        // Favor short sequences so both ends get hit often.
        if (r < 60)
            s.frames = 9'($urandom_range(2, 12));
        else if (r < 70)
            s.frames = 9'($urandom_range(0, 1));
        else if (r < 90)
            s.frames = 9'($urandom_range(13, 255));
        else
            s.frames = 9'($urandom_range(256, 511));
        s.delays = {rand_delay(), rand_delay(), rand_delay()};
        if ($urandom_range(0, 1) == 0)
            s.thresholds = {7'($urandom_range(50, 100)), 7'($urandom_range(0, 50))};
        else
            s.thresholds = 14'($urandom_range(0, 16383));
        s.peak_min = rand_pause();
        s.peak_max = rand_pause();
        s.rest_min = rand_pause();
        s.rest_max = rand_pause();
        if ($urandom_range(0, 1) == 0)
            s.span = 8'($urandom_range(0, 10));
        else
            s.span = 8'($urandom_range(0, 255));
        return s;
    endfunction

    // Offer one sample after an optional gap and hold it until the request is taken.
    task automatic send_sample(logic [31:0] now, logic [31:0] jrnd, logic [31:0] prnd);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= now;
        jitter_random <= jrnd;
        pause_random  <= prnd;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        board.note_sample(now, jrnd, prnd);
    endtask

    task automatic step_at_deadline(logic [31:0] jrnd, logic [31:0] prnd);
        send_sample(board.deadline, jrnd, prnd);
    endtask

    // Time stamps mostly land on the deadline (step) or just short of it (idle);
    // the rest jump ahead, land anywhere, or sit just below the wrap point.
    task automatic send_random_sample();
        logic [31:0] now;
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            now = board.deadline + $urandom_range(0, 3);
        else if (r < 75)
            now = board.deadline - $urandom_range(1, 5);
        else if (r < 85)
            now = board.deadline + $urandom_range(0, 100000);
        else if (r < 95)
            now = $urandom();
        else
            now = 32'hFFFF_FFFF - $urandom_range(0, 4200);
        send_sample(now, $urandom(), $urandom());
    endtask

    // Drop the sample request and wait until every owed frame has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Hold one register write request until taken; the caller drops cfg_valid.
    task automatic write_cfg(pfs_pkg::cfg_reg_t idx, logic [35:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        board.load_reg(idx, data);
    endtask

    task automatic apply_settings(settings_t s);
        wait_drained();
        write_cfg(pfs_pkg::CFG_FRAME_COUNT, {27'b0, s.frames});
        write_cfg(pfs_pkg::CFG_PHASE_DELAYS, s.delays);
        write_cfg(pfs_pkg::CFG_PHASE_THRESHOLDS, {22'b0, s.thresholds});
        write_cfg(pfs_pkg::CFG_PEAK_PAUSE_MIN, {24'b0, s.peak_min});
        write_cfg(pfs_pkg::CFG_PEAK_PAUSE_MAX, {24'b0, s.peak_max});
        write_cfg(pfs_pkg::CFG_REST_PAUSE_MIN, {24'b0, s.rest_min});
        write_cfg(pfs_pkg::CFG_REST_PAUSE_MAX, {24'b0, s.rest_max});
        write_cfg(pfs_pkg::CFG_JITTER_SPAN, {28'b0, s.span});
        cfg_valid <= 1'b0;
    endtask

    // Result side: check every taken result, then pick the next ready level.
    // A hold request from the sender turns into one long stretch with ready low,
    // counted here, while the sender keeps offering samples.
    initial
    begin : result_side
        int gap;
        int hold_served;
        gap = 0;
        hold_served = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(frame_index, rising, stepped);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                gap = calm ? 0 : pick_gap();
            end
        end
    end

    // Hard stop if the block hangs.
    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        board = new();
        calm = 1'b0;
        hold_requests = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        now_ms        <= '0;
        jitter_random <= '0;
        pause_random  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= pfs_pkg::CFG_FRAME_COUNT;
        cfg_data      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: two frames, so every step hits an end; the first sample
        // meets the zero deadline at time zero.
        send_sample(32'd0, 32'd0, 32'd0);
        send_sample(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Six frames, distinct delays per phase, empty rest range. The first step
        // lands at the top of the clock so the deadline wraps past zero; the next
        // sample then sits below the wrapped deadline and must idle.
        cfg_now.frames     = 9'd6;
        cfg_now.delays     = {12'd300, 12'd200, 12'd100};
        cfg_now.thresholds = {7'd60, 7'd20};
        cfg_now.peak_min   = 12'd10;
        cfg_now.peak_max   = 12'd20;
        cfg_now.rest_min   = 12'd30;
        cfg_now.rest_max   = 12'd30;
        cfg_now.span       = 8'd5;
        apply_settings(cfg_now);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'd10, $urandom(), $urandom());
        repeat (3) step_at_deadline($urandom(), $urandom());

        // Shrink the sequence under a rising index: clamp to the last frame,
        // idle once, then walk back down into the empty rest range.
        cfg_now.frames = 9'd3;
        apply_settings(cfg_now);
        step_at_deadline($urandom(), $urandom());
        send_sample(board.deadline - 32'd1, $urandom(), $urandom());
        repeat (2) step_at_deadline($urandom(), $urandom());

        // Zero delays with the widest jitter: negative delays clamp to zero.
        cfg_now.frames = 9'd9;
        cfg_now.delays = '0;
        cfg_now.span   = 8'hFF;
        apply_settings(cfg_now);
        repeat (4) step_at_deadline($urandom(), $urandom());

        // Reverse at five frames, then drop to a count below two while returning
        // so the index sits far beyond the last frame and just decrements.
        cfg_now.frames = 9'd5;
        apply_settings(cfg_now);
        step_at_deadline($urandom(), $urandom());
        cfg_now.frames = 9'd0;
        apply_settings(cfg_now);
        repeat (2) step_at_deadline($urandom(), $urandom());

        // Random phases, each under fresh settings; the first two pin the register
        // extremes, the third shrinks right after a long sequence.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: cfg_now = '0;
                1:
                begin
                    cfg_now.frames     = 9'h1FF;
                    cfg_now.delays     = '1;
                    cfg_now.thresholds = '1;
                    cfg_now.peak_min   = 12'hFFF;
                    cfg_now.peak_max   = 12'hFFF;
                    cfg_now.rest_min   = 12'h000;
                    cfg_now.rest_max   = 12'hFFF;
                    cfg_now.span       = 8'hFF;
                end
                2:
                begin
                    cfg_now = random_settings();
                    cfg_now.frames = 9'd3;
                end
                default: cfg_now = random_settings();
            endcase
            apply_settings(cfg_now);
            calm = (p == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Stall the result side for a long stretch and keep pushing samples.
                if ((p == 3 || p == 8) && i == 40)
                    hold_requests++;
                // Pause the sender until the block has drained.
                if (p == 6 && i == 65)
                    wait_drained();
                send_random_sample();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d samples over %0d random phases: %0d steps, %0d end reversals",
                 board.samples, NUM_PHASES, board.steps, board.reversals);
        $display("negative delays clamped %0d times, steps from beyond the last frame %0d",
                 board.clamped, board.beyond_last);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
